/* sv/eec_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// eec_pkg
// Shared types and constants for the EtherType classifier.
// ----------------------------------------------------------------------------
package eec_pkg;

	localparam int TABLE_ENTRIES = 8;
	localparam int ENTRY_W       = 16;
	localparam int REG_W         = 64;
	localparam int ADDR_W        = 5;

	localparam logic [15:0] MIN_TYPE    = 16'h0600;
	localparam logic [15:0] HEADER_LEN  = 16'd14;
	localparam logic [15:0] TYPE_OFFSET = 16'd12;
	localparam logic [15:0] DEST_END    = 16'd6;
	localparam logic [15:0] POS_MAX     = 16'hFFFF;

	typedef enum logic [1:0] {
		VERDICT_DISPATCH    = 2'd0,
		VERDICT_SHORT       = 2'd1,
		VERDICT_LOW_TYPE    = 2'd2,
		VERDICT_UNSUPPORTED = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		REG_TABLE_LOW  = 2'd0,
		REG_TABLE_HIGH = 2'd1,
		REG_ENABLE     = 2'd2,
		REG_NONE       = 2'd3
	} reg_idx_t;

	// Pick the EtherType of one table entry out of the two table registers.
	function automatic logic [ENTRY_W-1:0] entry_type(
		input logic [REG_W-1:0] tbl_low,
		input logic [REG_W-1:0] tbl_high,
		input logic [2:0]       idx
	);
		logic [REG_W-1:0] sel;
		sel = idx[2] ? tbl_high : tbl_low;
		return sel[idx[1:0]*ENTRY_W +: ENTRY_W];
	endfunction

endpackage
`default_nettype wire

/* sv/ethernet_ethertype_classifier_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ethernet_ethertype_classifier_top
// Ethernet II header parser with EtherType dispatch over an eight-entry table.
// ----------------------------------------------------------------------------
// Frame bytes enter one beat per cycle on the input channel, last_byte marking
// the final byte. The block captures the destination MAC (bytes 0..5), the
// source MAC (bytes 6..11) and the big-endian EtherType (bytes 12..13) and,
// on the last byte, emits exactly one verdict beat: dispatched (with the
// lowest enabled matching entry), too short (under 14 bytes), type below
// 0x0600, or no matching entry. Non-final bytes produce no output beat.
// Throughput is one byte per cycle; the last byte of a frame passes the input
// register, then its verdict is held in the result register. The only
// stall is a last byte waiting while the previous verdict is still held in
// the result register. The three totals wrap at 32 bits and show the counts
// including the frame of the current verdict. Table registers are written
// through the APB port at byte addresses 0x00 (entries 0..3), 0x08
// (entries 4..7) and 0x10 (enable bits); write them only while idle.
// ----------------------------------------------------------------------------
module ethernet_ethertype_classifier_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// APB configuration port
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [eec_pkg::ADDR_W-1:0] paddr,
	input  wire logic [eec_pkg::REG_W-1:0]  pwdata,
	output logic      [eec_pkg::REG_W-1:0]  prdata,
	output logic                           pready,
	// byte input channel
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [7:0]                data_byte,
	input  wire logic                      last_byte,
	// verdict output channel
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic      [1:0]                verdict,
	output logic      [2:0]                entry_index,
	output logic      [15:0]               frame_type,
	output logic      [47:0]               dest_mac,
	output logic      [47:0]               src_mac,
	output logic      [15:0]               payload_bytes,
	output logic      [31:0]               received_total,
	output logic      [31:0]               malformed_total,
	output logic      [31:0]               unsupported_total
);
	import eec_pkg::*;

	// configuration registers
	logic [REG_W-1:0]         tbl_low_q;
	logic [REG_W-1:0]         tbl_high_q;
	logic [TABLE_ENTRIES-1:0] enable_q;
	reg_idx_t                 wr_idx;
	logic                     wr_en;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv_s1;

	// frame state
	logic [15:0] pos_q;
	logic [47:0] dest_q;
	logic [47:0] src_q;
	logic [15:0] type_q;

	// counters
	logic [31:0] rx_cnt_q;
	logic [31:0] bad_cnt_q;
	logic [31:0] unsup_cnt_q;

	// result register
	logic        out_valid_q;
	verdict_t    verdict_q;
	logic [2:0]  index_q;
	logic [15:0] ftype_q;
	logic [47:0] dest_out_q;
	logic [47:0] src_out_q;
	logic [15:0] payload_q;

	// next-state logic
	logic [15:0] pos_nxt;
	logic [47:0] dest_nxt;
	logic [47:0] src_nxt;
	logic [15:0] type_nxt;
	logic        too_short;
	logic        low_type;
	logic        hit;
	logic [2:0]  hit_idx;
	verdict_t    verdict_nxt;
	logic        emit;

	// ---------------------------------------------------------------- APB
	assign pready = 1'b1;
	assign wr_idx = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_low_q  <= '0;
			tbl_high_q <= '0;
			enable_q   <= '0;
		end else if (wr_en) begin
			case (wr_idx)
				REG_TABLE_LOW:  tbl_low_q  <= pwdata;
				REG_TABLE_HIGH: tbl_high_q <= pwdata;
				REG_ENABLE:     enable_q   <= pwdata[TABLE_ENTRIES-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		case (wr_idx)
			REG_TABLE_LOW:  prdata = tbl_low_q;
			REG_TABLE_HIGH: prdata = tbl_high_q;
			REG_ENABLE:     prdata = {{(REG_W-TABLE_ENTRIES){1'b0}}, enable_q};
			default:        prdata = '0;
		endcase
	end

	// ---------------------------------------------------------- handshakes
	// A non-final byte always drains; a final byte needs room in the
	// result register.
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign emit     = adv_s1 && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// ------------------------------------------------------ header capture
	always_comb begin
		pos_nxt  = (pos_q == POS_MAX) ? pos_q : pos_q + 16'd1;
		dest_nxt = dest_q;
		src_nxt  = src_q;
		type_nxt = type_q;
		if (pos_q < DEST_END) begin
			dest_nxt = {dest_q[39:0], byte_s1};
		end else if (pos_q < TYPE_OFFSET) begin
			src_nxt = {src_q[39:0], byte_s1};
		end else if (pos_q == TYPE_OFFSET) begin
			type_nxt = {byte_s1, type_q[7:0]};
		end else if (pos_q == TYPE_OFFSET + 16'd1) begin
			type_nxt = {type_q[15:8], byte_s1};
		end
	end

	// ------------------------------------------------------ classification
	// Scan from the top so the lowest enabled match is the one left standing.
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (enable_q[i] && entry_type(tbl_low_q, tbl_high_q, 3'(i)) == type_nxt) begin
				hit     = 1'b1;
				hit_idx = 3'(i);
			end
		end
	end

	assign too_short = pos_nxt < HEADER_LEN;
	assign low_type  = type_nxt < MIN_TYPE;

	always_comb begin
		if (too_short) begin
			verdict_nxt = VERDICT_SHORT;
		end else if (low_type) begin
			verdict_nxt = VERDICT_LOW_TYPE;
		end else if (hit) begin
			verdict_nxt = VERDICT_DISPATCH;
		end else begin
			verdict_nxt = VERDICT_UNSUPPORTED;
		end
	end

	// ---------------------------------------------------------- frame state
	// Captures are fully overwritten before any frame long enough to use
	// them, so only the byte position needs reset and clearing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (adv_s1) begin
			pos_q <= last_s1 ? 16'd0 : pos_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			dest_q <= dest_nxt;
			src_q  <= src_nxt;
			type_q <= type_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_cnt_q    <= '0;
			bad_cnt_q   <= '0;
			unsup_cnt_q <= '0;
		end else if (emit) begin
			case (verdict_nxt)
				VERDICT_SHORT,
				VERDICT_LOW_TYPE:    bad_cnt_q <= bad_cnt_q + 32'd1;
				VERDICT_UNSUPPORTED: begin
					rx_cnt_q    <= rx_cnt_q + 32'd1;
					unsup_cnt_q <= unsup_cnt_q + 32'd1;
				end
				default:             rx_cnt_q <= rx_cnt_q + 32'd1;
			endcase
		end
	end

	// ------------------------------------------------------ result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			verdict_q  <= verdict_nxt;
			index_q    <= (verdict_nxt == VERDICT_DISPATCH) ? hit_idx : 3'd0;
			ftype_q    <= too_short ? 16'd0 : type_nxt;
			dest_out_q <= too_short ? 48'd0 : dest_nxt;
			src_out_q  <= too_short ? 48'd0 : src_nxt;
			payload_q  <= too_short ? 16'd0 : pos_nxt - HEADER_LEN;
		end
	end

	// Counters change only when a new verdict loads, so they drive the
	// totals directly.
	assign out_valid         = out_valid_q;
	assign verdict           = verdict_q;
	assign entry_index       = index_q;
	assign frame_type        = ftype_q;
	assign dest_mac          = dest_out_q;
	assign src_mac           = src_out_q;
	assign payload_bytes     = payload_q;
	assign received_total    = rx_cnt_q;
	assign malformed_total   = bad_cnt_q;
	assign unsupported_total = unsup_cnt_q;

endmodule
`default_nettype wire
